// ===== design/gceb_pkg.sv =====
// ----------------------------------------------------------------------------
// gceb_pkg
// Shared types and constants for the glyph color expansion blit core.
// ----------------------------------------------------------------------------
package gceb_pkg;

  localparam int IconWDef     = 16;
  localparam int IconHDef     = 16;
  localparam int PixelBitsDef = 24;

  localparam int QDepth = 4;

  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CFG_FG_LEFT     = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG_LEFT     = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_FG_RIGHT    = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_BG_RIGHT    = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPLIT_COL   = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_X    = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_ORIGIN_Y    = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_WIDTH = 4'd7;

  typedef struct packed {
    logic [23:0] fg_left;
    logic [23:0] bg_left;
    logic [23:0] fg_right;
    logic [23:0] bg_right;
    logic [7:0]  split_col;
    logic [7:0]  origin_x;
    logic [7:0]  origin_y;
    logic [7:0]  glyph_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0] bits;
    logic [7:0] mask;
    logic [8:0] base_x;
    logic [3:0] py;
  } qent_t;

  typedef struct packed {
    logic  push;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== design/gceb_front.sv =====
// ----------------------------------------------------------------------------
// gceb_front
// Accepts glyph bytes, tracks row and byte column, builds the write mask.
// ----------------------------------------------------------------------------
module gceb_front #(
  parameter int ICON_W = gceb_pkg::IconWDef,
  parameter int ICON_H = gceb_pkg::IconHDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gceb_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  logic [7:0]       in_bits,
  input  logic             in_eog,
  input  logic             q_full,
  output logic             in_ready,
  output gceb_pkg::qpush_t q_push
);

  logic [4:0] byte_col_r, byte_col_nxt;
  logic [7:0] glyph_row_r, glyph_row_nxt;
  logic [5:0] row_len;
  logic [8:0] py9;
  logic       row_ok;
  logic [7:0] mask;
  logic [8:0] base_x;
  logic [4:0] col_inc;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign row_len = 6'(({1'b0, cfg.glyph_width} + 9'd7) >> 3);
  assign py9     = {1'b0, cfg.origin_y} + {1'b0, glyph_row_r};
  assign row_ok  = ({1'b0, byte_col_r} < row_len) && (py9 < 9'(ICON_H));
  assign base_x  = {1'b0, cfg.origin_x} + {1'b0, byte_col_r, 3'b000};

  always_comb begin
    logic [7:0] gx;
    logic [8:0] px;
    for (int b = 0; b < 8; b++) begin
      gx      = {byte_col_r, 3'(b)};
      px      = {1'b0, cfg.origin_x} + {1'b0, gx};
      mask[b] = row_ok && (gx < cfg.glyph_width) && (px < 9'(ICON_W));
    end
  end

  assign q_push.push       = accept && (mask != 8'd0);
  assign q_push.ent.bits   = in_bits;
  assign q_push.ent.mask   = mask;
  assign q_push.ent.base_x = base_x;
  assign q_push.ent.py     = py9[3:0];

  assign col_inc = byte_col_r + 5'd1;

  always_comb begin
    byte_col_nxt  = byte_col_r;
    glyph_row_nxt = glyph_row_r;
    if (accept) begin
      if (in_eog) begin
        byte_col_nxt  = 5'd0;
        glyph_row_nxt = 8'd0;
      end else if (({1'b0, col_inc} >= row_len) || (col_inc == 5'd0)) begin
        byte_col_nxt = 5'd0;
        if (glyph_row_r != 8'hFF) begin
          glyph_row_nxt = glyph_row_r + 8'd1;
        end
      end else begin
        byte_col_nxt = col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_col_r  <= 5'd0;
      glyph_row_r <= 8'd0;
    end else begin
      byte_col_r  <= byte_col_nxt;
      glyph_row_r <= glyph_row_nxt;
    end
  end

endmodule

// ===== design/gceb_queue.sv =====
// ----------------------------------------------------------------------------
// gceb_queue
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module gceb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  gceb_pkg::qpush_t q_push,
  input  logic             pop,
  output gceb_pkg::qent_t  head,
  output gceb_pkg::qstat_t stat
);

  localparam int PtrW = $clog2(gceb_pkg::QDepth);
  localparam int CntW = $clog2(gceb_pkg::QDepth + 1);

  gceb_pkg::qent_t ent_r [gceb_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (count_r == CntW'(gceb_pkg::QDepth));
  assign stat.empty = (count_r == '0);
  assign do_push    = q_push.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(gceb_pkg::QDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(gceb_pkg::QDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= q_push.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/gceb_back.sv =====
// ----------------------------------------------------------------------------
// gceb_back
// Expands one queued byte into pixel writes, one per cycle while out_ready
// does not stall the output register, through an output register.
// ----------------------------------------------------------------------------
module gceb_back #(
  parameter int PIXEL_BITS = gceb_pkg::PixelBitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gceb_pkg::cfg_t   cfg,
  input  gceb_pkg::qent_t  head,
  input  gceb_pkg::qstat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       out_x,
  output logic [3:0]       out_y,
  output logic [23:0]      out_value,
  output logic             out_last
);

  localparam logic [23:0] ColMask =
    (PIXEL_BITS >= 24) ? {24{1'b1}} : 24'((33'd1 << PIXEL_BITS) - 33'd1);

  gceb_pkg::qent_t cur_r;
  logic            cur_valid_r, cur_valid_nxt;
  logic [7:0]      rem_r;
  logic [2:0]      idx;
  logic [7:0]      rem_after;
  logic [8:0]      px9;
  logic            on, right, last, emit, take;
  logic [23:0]     colour;

  logic            out_valid_r, out_valid_nxt;
  logic [3:0]      out_x_r, out_y_r;
  logic [23:0]     out_value_r;
  logic            out_last_r;

  always_comb begin
    idx = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (rem_r[b]) begin
        idx = 3'(b);
      end
    end
  end

  assign rem_after = rem_r & ~(8'd1 << idx);
  assign last      = (rem_after == 8'd0);
  assign px9       = cur_r.base_x + {6'd0, idx};
  assign on        = cur_r.bits[idx];
  assign right     = (px9 >= {1'b0, cfg.split_col});
  assign colour    = ColMask & (right ? (on ? cfg.fg_right : cfg.bg_right)
                                      : (on ? cfg.fg_left : cfg.bg_left));

  assign emit = cur_valid_r && (!out_valid_r || out_ready);
  assign take = !cur_valid_r || (emit && last);
  assign pop  = take && !stat.empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    if (take) begin
      cur_valid_nxt = !stat.empty;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= head;
      rem_r <= head.mask;
    end else if (emit) begin
      rem_r <= rem_after;
    end
    if (emit) begin
      out_x_r     <= px9[3:0];
      out_y_r     <= cur_r.py;
      out_value_r <= colour;
      out_last_r  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/glyph_color_expansion_blit_core.sv =====
// ----------------------------------------------------------------------------
// glyph_color_expansion_blit_core
// Expands monochrome glyph bytes into colored pixel writes clipped to an icon.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | tdata glyph byte, tlast end of glyph
//   out_    | out | out_tvalid/tready  | tdata x, y, value; tlast last of byte
//   cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// one pixel write per cycle unless out_tready stalls; a byte with n writes occupies the back end for all n
// the front end takes a byte per cycle while the queue has room
// a fully clipped byte is accepted by the front end and never reaches the back end
// reset clears counters, queue and output; colors return to defaults
// cfg_ready is always high
// ----------------------------------------------------------------------------
module glyph_color_expansion_blit_core #(
  parameter int ICON_W     = gceb_pkg::IconWDef,
  parameter int ICON_H     = gceb_pkg::IconHDef,
  parameter int PIXEL_BITS = gceb_pkg::PixelBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // glyph_bits
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // pixel_x, pixel_y, pixel_value
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gceb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gceb_pkg::CfgDataW-1:0]  cfg_data
);

  gceb_pkg::cfg_t   cfg_r;
  gceb_pkg::qpush_t q_push;
  gceb_pkg::qent_t  q_head;
  gceb_pkg::qstat_t q_stat;
  logic             q_pop;
  logic [3:0]       out_x, out_y;
  logic [23:0]      out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_left     <= 24'hFFFFFF;
      cfg_r.bg_left     <= 24'h000000;
      cfg_r.fg_right    <= 24'hFFFFFF;
      cfg_r.bg_right    <= 24'h000000;
      cfg_r.split_col   <= 8'hFF;
      cfg_r.origin_x    <= 8'd0;
      cfg_r.origin_y    <= 8'd0;
      cfg_r.glyph_width <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gceb_pkg::CFG_FG_LEFT:     cfg_r.fg_left     <= cfg_data;
        gceb_pkg::CFG_BG_LEFT:     cfg_r.bg_left     <= cfg_data;
        gceb_pkg::CFG_FG_RIGHT:    cfg_r.fg_right    <= cfg_data;
        gceb_pkg::CFG_BG_RIGHT:    cfg_r.bg_right    <= cfg_data;
        gceb_pkg::CFG_SPLIT_COL:   cfg_r.split_col   <= cfg_data[7:0];
        gceb_pkg::CFG_ORIGIN_X:    cfg_r.origin_x    <= cfg_data[7:0];
        gceb_pkg::CFG_ORIGIN_Y:    cfg_r.origin_y    <= cfg_data[7:0];
        gceb_pkg::CFG_GLYPH_WIDTH: cfg_r.glyph_width <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  gceb_front #(
    .ICON_W (ICON_W),
    .ICON_H (ICON_H)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_bits  (in_tdata),
    .in_eog   (in_tlast),
    .q_full   (q_stat.full),
    .in_ready (in_tready),
    .q_push   (q_push)
  );

  gceb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .head   (q_head),
    .stat   (q_stat)
  );

  gceb_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_value, out_y, out_x};

  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  a_ready_follows_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !q_stat.full)
    else $error("input ready out of step with queue");

  a_x_in_icon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((ICON_W > 16) || (32'(out_tdata[3:0]) < 32'(ICON_W))))
    else $error("pixel column outside icon");

  a_y_in_icon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((ICON_H > 16) || (32'(out_tdata[7:4]) < 32'(ICON_H))))
    else $error("pixel row outside icon");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
